// ===== src/mbe_pkg.sv =====
`default_nettype none
package mbe_pkg;

   localparam int POINT_W = 32;                 // c_real / c_imag
   localparam int ORBIT_W = 40;                 // saturated orbit value
   localparam int COUNT_W = 16;                 // step counter / limit
   localparam int HALF_W  = ORBIT_W / 2;        // multiplier operand split
   localparam int PP_W    = ORBIT_W + HALF_W;   // one partial product
   localparam int PROD_W  = 2 * ORBIT_W;        // full magnitude product
   localparam int TERM_W  = 62;                 // scaled, clamped, signed product
   localparam int NEXT_W  = 64;                 // unsaturated next orbit value
   localparam int RSP_W   = 8;

   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd100;
   localparam logic [TERM_W-1:0]  PROD_LIM = TERM_W'(1) << 60;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_EVAL,
      ST_STEP,
      ST_DONE
   } mbe_state_type;

   typedef struct packed {
      logic load;         // capture a new point, orbit starts at c
      logic mul_lo;       // partial products against low operand halves
      logic mul_hi;       // partial products against high operand halves
      logic acc;          // combine partial products
      logic eval;         // escape test and scaled terms
      logic step;         // z = z*z + c
      logic load_result;  // move verdict into the output register
   } mbe_cmd_type;

   typedef struct packed {
      logic escaped;      // |z|^2 > 4 on the orbit just stepped
      logic at_limit;     // step count reached the iteration limit
   } mbe_status_type;

endpackage
`default_nettype wire

// ===== src/mbe_ctrl.sv =====
`default_nettype none
module mbe_ctrl
   import mbe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire mbe_status_type status,
   output mbe_cmd_type         cmd
);

   mbe_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.escaped || status.at_limit) state_in = ST_DONE;
            else                                   state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_MUL_LO;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_result)  rsp_valid_in = 1'b1;
      else if (rsp_tready)  rsp_valid_in = 1'b0;
      else                  rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== src/mbe_dpath.sv =====
`default_nettype none
module mbe_dpath
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [COUNT_W-1:0]  csr_wr_data,
   input  wire logic [POINT_W-1:0]  c_real,
   input  wire logic [POINT_W-1:0]  c_imag,
   input  wire mbe_cmd_type         cmd,
   output mbe_status_type           status,
   output logic                     inside_res
);

   localparam int SUM_W = PROD_W + 1;
   localparam int CMP_W = (2 * FRAC_BITS + 3 > SUM_W) ? 2 * FRAC_BITS + 3 : SUM_W;
   localparam logic [CMP_W-1:0] ESC_LIMIT = CMP_W'(1) << (2 * FRAC_BITS + 2);
   localparam logic signed [NEXT_W-1:0] ORBIT_MAX = NEXT_W'((64'sd1 <<< (ORBIT_W - 1)) - 1);
   localparam logic signed [NEXT_W-1:0] ORBIT_MIN = -(NEXT_W'(64'sd1 <<< (ORBIT_W - 1)));

   // floor(p / 2^s) with sign applied, magnitude clamped to 2^60
   function automatic logic signed [TERM_W-1:0] scale_term(
      input logic [PROD_W-1:0] p,
      input logic              neg,
      input int                s
   );
      logic [PROD_W-1:0] q;
      logic [PROD_W-1:0] rem_mask;
      logic [TERM_W-1:0] m;
      q        = p >> s;
      rem_mask = (PROD_W'(1) << s) - PROD_W'(1);
      if (q > PROD_W'(PROD_LIM)) m = PROD_LIM;
      else m = q[TERM_W-1:0] + TERM_W'(neg && ((p & rem_mask) != '0));
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [ORBIT_W-1:0] sat_orbit(input logic signed [NEXT_W-1:0] v);
      if (v > ORBIT_MAX)      return ORBIT_W'(ORBIT_MAX);
      else if (v < ORBIT_MIN) return ORBIT_W'(ORBIT_MIN);
      else                    return v[ORBIT_W-1:0];
   endfunction

   logic [COUNT_W-1:0]        max_iter_ff;
   logic signed [POINT_W-1:0] c_r_ff, c_i_ff;
   logic signed [ORBIT_W-1:0] z_r_ff, z_i_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [ORBIT_W-1:0]        mag_r_ff, mag_i_ff;
   logic [PP_W-1:0]           pp_ff [3];
   logic [PP_W-1:0]           lo_ff [3];
   logic [PROD_W-1:0]         prod_ff [3];
   logic signed [TERM_W-1:0]  t_rr_ff, t_ii_ff, t_ri_ff;
   logic                      verdict_ff;
   logic                      inside_ff;

   logic [ORBIT_W-1:0]        mag_r, mag_i;
   logic [CMP_W-1:0]          sq_sum;
   logic                      escaped_w;
   logic signed [NEXT_W-1:0]  next_r, next_i;

   assign mag_r = z_r_ff[ORBIT_W-1] ? ORBIT_W'(-z_r_ff) : ORBIT_W'(z_r_ff);
   assign mag_i = z_i_ff[ORBIT_W-1] ? ORBIT_W'(-z_i_ff) : ORBIT_W'(z_i_ff);

   // escape test only after a step has been taken
   assign sq_sum    = CMP_W'(prod_ff[0]) + CMP_W'(prod_ff[1]);
   assign escaped_w = (count_ff != '0) && (sq_sum > ESC_LIMIT);

   assign next_r = NEXT_W'(t_rr_ff) - NEXT_W'(t_ii_ff) + NEXT_W'(c_r_ff);
   assign next_i = NEXT_W'(t_ri_ff) + NEXT_W'(c_i_ff);

   assign status.escaped  = escaped_w;
   assign status.at_limit = (count_ff == max_iter_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_wr_en) begin
         max_iter_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_r_ff   <= $signed(c_real);
         c_i_ff   <= $signed(c_imag);
         z_r_ff   <= ORBIT_W'($signed(c_real));
         z_i_ff   <= ORBIT_W'($signed(c_imag));
         count_ff <= '0;
      end
      if (cmd.mul_lo) begin
         mag_r_ff <= mag_r;
         mag_i_ff <= mag_i;
         pp_ff[0] <= PP_W'(mag_r) * PP_W'(mag_r[HALF_W-1:0]);
         pp_ff[1] <= PP_W'(mag_i) * PP_W'(mag_i[HALF_W-1:0]);
         pp_ff[2] <= PP_W'(mag_r) * PP_W'(mag_i[HALF_W-1:0]);
      end
      if (cmd.mul_hi) begin
         lo_ff    <= pp_ff;
         pp_ff[0] <= PP_W'(mag_r_ff) * PP_W'(mag_r_ff[ORBIT_W-1:HALF_W]);
         pp_ff[1] <= PP_W'(mag_i_ff) * PP_W'(mag_i_ff[ORBIT_W-1:HALF_W]);
         pp_ff[2] <= PP_W'(mag_r_ff) * PP_W'(mag_i_ff[ORBIT_W-1:HALF_W]);
      end
      if (cmd.acc) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= PROD_W'(lo_ff[k]) + (PROD_W'(pp_ff[k]) << HALF_W);
         end
      end
      if (cmd.eval) begin
         verdict_ff <= !escaped_w;
         t_rr_ff    <= scale_term(prod_ff[0], 1'b0, FRAC_BITS);
         t_ii_ff    <= scale_term(prod_ff[1], 1'b0, FRAC_BITS);
         // cross term carries 2*zr*zi, hence one less bit of shift
         t_ri_ff    <= scale_term(prod_ff[2], z_r_ff[ORBIT_W-1] ^ z_i_ff[ORBIT_W-1],
                                  FRAC_BITS - 1);
      end
      if (cmd.step) begin
         z_r_ff   <= sat_orbit(next_r);
         z_i_ff   <= sat_orbit(next_i);
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.load_result) begin
         inside_ff <= verdict_ff;
      end
   end

   assign inside_res = inside_ff;

endmodule
`default_nettype wire

// ===== src/mandelbrot_escape_test.sv =====
`default_nettype none
// channel   dir  handshake                tdata / data
// req       in   req_tvalid/req_tready    [31:0] c_real, [63:32] c_imag
// rsp       out  rsp_tvalid/rsp_tready    [0] inside_res
// csr       in   csr_wr_en                [15:0] iteration limit
//
// One point at a time. Each orbit step runs ST_MUL_LO and ST_MUL_HI on three
// 40x20 multipliers, then a product combine, an escape test and a z update.
// A point's result loads into the output register after its final escape test,
// raising rsp_tvalid; the next point can be accepted the cycle after it loads.
// Reset is synchronous; the iteration limit comes back as 100.
// The result sits in an output register; a stalled result holds the next
// point's verdict in the done state until the register frees.
module mandelbrot_escape_test
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [2*POINT_W-1:0] req_tdata,   // [31:0] c_real, [63:32] c_imag
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,   // [0] inside_res, rest zero
   input  wire logic                 csr_wr_en,
   input  wire logic [COUNT_W-1:0]   csr_wr_data
);

   mbe_cmd_type    cmd;
   mbe_status_type status;
   logic           inside_res;

   mbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mbe_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .c_real      (req_tdata[POINT_W-1:0]),
      .c_imag      (req_tdata[2*POINT_W-1:POINT_W]),
      .cmd         (cmd),
      .status      (status),
      .inside_res  (inside_res)
   );

   assign rsp_tdata = {{(RSP_W-1){1'b0}}, inside_res};

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul_lo, cmd.mul_hi, cmd.acc, cmd.eval, cmd.step,
                cmd.load_result}))
      else $error("more than one datapath command at once");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a point is in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_result))
      else $error("response raised without a result load");

   a_step_after_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> $past(cmd.eval) && !$past(status.escaped) && !$past(status.at_limit))
      else $error("orbit step without a passing evaluation");

endmodule
`default_nettype wire
